// File: rtl/core/dsd_pkg.sv
// Shared types, codes and microprogram for the deck shuffle and deal engine.
package dsd_pkg;

  // Fixed field widths.
  localparam int unsigned CARD_W   = 6;
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned DIVCNT_W = 5;

  // Generator state after reset.
  localparam logic [WORD_W-1:0] RNG_RESET = 32'habcdef01;
  // Count of the last step of the bit-serial remainder.
  localparam logic [DIVCNT_W-1:0] DIV_LAST = 5'd31;

  // Operation codes carried in the request.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_RESEED  = 2'd0,
    FUNC_SHUFFLE = 2'd1,
    FUNC_DEAL    = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  // Request and response payloads.
  typedef struct packed {
    func_t             func;
    logic [WORD_W-1:0] seed_value;
  } req_t;

  typedef struct packed {
    logic [CARD_W-1:0] card;
    logic              deck_empty;
  } rsp_t;

  // Microprogram step addresses.
  typedef enum logic [3:0] {
    U_FETCH   = 4'd0,
    U_DEAL_RD = 4'd1,
    U_DEAL_WR = 4'd2,
    U_SH_INIT = 4'd3,
    U_RNG     = 4'd4,
    U_DIV     = 4'd5,
    U_SWAP_RD = 4'd6,
    U_SWAP_WI = 4'd7,
    U_SWAP_WJ = 4'd8,
    U_SH_DONE = 4'd9
  } upc_t;

  // Sequencing conditions.
  typedef enum logic [2:0] {
    C_GOTO,      // always go to the target
    C_DISPATCH,  // decode the accepted request
    C_WAIT_OUT,  // hold until the response register is free
    C_DIV_LOOP,  // hold until the last remainder step
    C_SWAP_LOOP  // back to the generator step unless the last swap
  } cond_t;

  // One control word of the microprogram.
  typedef struct packed {
    logic  accept;
    logic  rd_deal;
    logic  out_load;
    logic  clear;
    logic  rng_step;
    logic  div_step;
    logic  rd_swap;
    logic  wr_i;
    logic  wr_j;
    logic  rewind;
    cond_t cond;
    upc_t  target;
  } ctl_t;

  // Control store: one word per step.
  function automatic ctl_t ucode(input upc_t pc);
    ctl_t w;
    w = '{default: '0, cond: C_GOTO, target: U_FETCH};
    unique case (pc)
      U_FETCH: begin
        w.accept = 1'b1;
        w.cond   = C_DISPATCH;
      end
      U_DEAL_RD: begin
        w.rd_deal = 1'b1;
        w.target  = U_DEAL_WR;
      end
      U_DEAL_WR: begin
        w.out_load = 1'b1;
        w.cond     = C_WAIT_OUT;
        w.target   = U_FETCH;
      end
      U_SH_INIT: begin
        w.clear  = 1'b1;
        w.target = U_RNG;
      end
      U_RNG: begin
        w.rng_step = 1'b1;
        w.target   = U_DIV;
      end
      U_DIV: begin
        w.div_step = 1'b1;
        w.cond     = C_DIV_LOOP;
        w.target   = U_SWAP_RD;
      end
      U_SWAP_RD: begin
        w.rd_swap = 1'b1;
        w.target  = U_SWAP_WI;
      end
      U_SWAP_WI: begin
        w.wr_i   = 1'b1;
        w.target = U_SWAP_WJ;
      end
      U_SWAP_WJ: begin
        w.wr_j   = 1'b1;
        w.cond   = C_SWAP_LOOP;
        w.target = U_SH_DONE;
      end
      U_SH_DONE: begin
        w.rewind = 1'b1;
        w.target = U_FETCH;
      end
      default: begin
        w.target = U_FETCH;
      end
    endcase
    return w;
  endfunction

  // One xorshift step with shifts 13, 17 and 5.
  function automatic logic [WORD_W-1:0] xorshift(input logic [WORD_W-1:0] s);
    logic [WORD_W-1:0] x;
    x = s ^ (s << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

endpackage

// File: rtl/core/deck_shuffle_and_deal.sv
// Deck shuffle and deal engine: microcoded sequencer, swap memory and serial remainder.
//
// Usage: requests arrive on req (req_valid/req_ready) as dsd_pkg::req_t.
// func selects reseed, shuffle or deal; seed_value matters only on reseed.
// Only a deal produces a response transaction on rsp (rsp_valid/rsp_ready):
// the next card, or card 0 with deck_empty set once the deck is used up.
// A request is taken only while the sequencer sits in its fetch step.
// Reseed completes in the fetch step that accepts it. A deal passes a read
// step and an output step to its response register. A shuffle runs DECK_SIZE-1
// swaps; each costs one generator step, the bit-serial remainder loop, a read
// and a write of each of the two entries on the single write port of the deck memory.
// The response register frees the request side: a new request is taken while
// a dealt card still waits. A following deal holds in its output step until
// the receiver takes the earlier card.
// Reset loads the generator with its fixed seed, marks every deck entry as
// unwritten (reads back identity order) and rewinds the deal position.
module deck_shuffle_and_deal #(
  parameter int unsigned DECK_SIZE = 52
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  dsd_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output dsd_pkg::rsp_t rsp
);

  localparam int unsigned IDX_W = (DECK_SIZE > 1) ? $clog2(DECK_SIZE) : 1;
  localparam int unsigned POS_W = $clog2(DECK_SIZE + 1);

  // Sequencer state.
  dsd_pkg::upc_t upc;
  dsd_pkg::upc_t upc_next;
  dsd_pkg::ctl_t ctl;

  // Datapath registers.
  logic [dsd_pkg::WORD_W-1:0]   rng;
  logic [dsd_pkg::WORD_W-1:0]   dividend;
  logic [IDX_W-1:0]             rem;
  logic [dsd_pkg::DIVCNT_W-1:0] div_cnt;
  logic [IDX_W-1:0]             idx_i;
  logic [POS_W-1:0]             deal_pos;

  // Deck memory with per-entry written flags.
  logic [dsd_pkg::CARD_W-1:0] mem [DECK_SIZE];
  logic [DECK_SIZE-1:0]       written;
  logic [dsd_pkg::CARD_W-1:0] rd_a;
  logic [dsd_pkg::CARD_W-1:0] rd_b;
  logic                       va;
  logic                       vb;
  logic [IDX_W-1:0]           addr_a_q;
  logic [IDX_W-1:0]           addr_b_q;

  logic                       deck_empty;
  logic [IDX_W-1:0]           addr_a;
  logic                       rd_en;
  logic [dsd_pkg::CARD_W-1:0] card_a;
  logic [dsd_pkg::CARD_W-1:0] card_b;
  logic                       wr_en;
  logic [IDX_W-1:0]           wr_addr;
  logic [dsd_pkg::CARD_W-1:0] wr_data;
  logic [IDX_W:0]             divisor;
  logic [IDX_W:0]             trial;
  logic                       out_free;
  logic                       req_fire;

  // Control word of the current step.
  always_comb begin
    ctl = dsd_pkg::ucode(upc);
  end

  assign req_ready  = ctl.accept;
  assign req_fire   = req_valid && ctl.accept;
  assign out_free   = !rsp_valid || rsp_ready;
  assign deck_empty = (deal_pos == POS_W'(DECK_SIZE));

  // Next step of the sequencer.
  always_comb begin
    upc_next = upc;
    unique case (ctl.cond)
      dsd_pkg::C_GOTO: begin
        upc_next = ctl.target;
      end
      dsd_pkg::C_DISPATCH: begin
        if (req_valid) begin
          unique case (req.func)
            dsd_pkg::FUNC_SHUFFLE: upc_next = dsd_pkg::U_SH_INIT;
            dsd_pkg::FUNC_DEAL:    upc_next = dsd_pkg::U_DEAL_RD;
            default:               upc_next = dsd_pkg::U_FETCH;
          endcase
        end
      end
      dsd_pkg::C_WAIT_OUT: begin
        if (out_free) begin
          upc_next = ctl.target;
        end
      end
      dsd_pkg::C_DIV_LOOP: begin
        if (div_cnt == dsd_pkg::DIV_LAST) begin
          upc_next = ctl.target;
        end
      end
      dsd_pkg::C_SWAP_LOOP: begin
        upc_next = (idx_i == IDX_W'(1)) ? ctl.target : dsd_pkg::U_RNG;
      end
      default: begin
        upc_next = dsd_pkg::U_FETCH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= dsd_pkg::U_FETCH;
    end else begin
      upc <= upc_next;
    end
  end

  // Generator: reseed on request, one xorshift step per swap.
  always_ff @(posedge clk) begin
    if (rst) begin
      rng <= dsd_pkg::RNG_RESET;
    end else if (req_fire && req.func == dsd_pkg::FUNC_RESEED) begin
      rng <= rng ^ (req.seed_value | dsd_pkg::WORD_W'(1));
    end else if (ctl.rng_step) begin
      rng <= dsd_pkg::xorshift(rng);
    end
  end

  // Bit-serial remainder of the random word by i+1, one dividend bit a cycle.
  assign divisor = {1'b0, idx_i} + (IDX_W + 1)'(1);
  assign trial   = {rem, dividend[dsd_pkg::WORD_W-1]};

  always_ff @(posedge clk) begin
    if (ctl.rng_step) begin
      dividend <= dsd_pkg::xorshift(rng);
      rem      <= '0;
      div_cnt  <= '0;
    end else if (ctl.div_step) begin
      dividend <= {dividend[dsd_pkg::WORD_W-2:0], 1'b0};
      div_cnt  <= div_cnt + dsd_pkg::DIVCNT_W'(1);
      if (trial >= divisor) begin
        rem <= IDX_W'(trial - divisor);
      end else begin
        rem <= trial[IDX_W-1:0];
      end
    end
  end

  // Swap index: starts at the top entry and counts down after each swap.
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      idx_i <= IDX_W'(DECK_SIZE - 1);
    end else if (ctl.wr_j) begin
      idx_i <= idx_i - IDX_W'(1);
    end
  end

  // Deal position.
  always_ff @(posedge clk) begin
    if (rst) begin
      deal_pos <= '0;
    end else if (ctl.rewind) begin
      deal_pos <= '0;
    end else if (ctl.out_load && out_free && !deck_empty) begin
      deal_pos <= deal_pos + POS_W'(1);
    end
  end

  // Memory port selection.
  assign rd_en   = ctl.rd_deal || ctl.rd_swap;
  assign addr_a  = ctl.rd_deal ? (deck_empty ? '0 : deal_pos[IDX_W-1:0]) : idx_i;
  assign wr_en   = ctl.wr_i || ctl.wr_j;
  assign wr_addr = ctl.wr_i ? addr_a_q : addr_b_q;
  assign wr_data = ctl.wr_i ? card_b : card_a;

  // An entry never written since the last clear reads as its own index.
  assign card_a = va ? rd_a : dsd_pkg::CARD_W'(addr_a_q);
  assign card_b = vb ? rd_b : dsd_pkg::CARD_W'(addr_b_q);

  // Deck memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a     <= mem[addr_a];
      rd_b     <= mem[rem];
      va       <= written[addr_a];
      vb       <= written[rem];
      addr_a_q <= addr_a;
      addr_b_q <= rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (ctl.clear) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.out_load && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load && out_free) begin
      rsp.card       <= deck_empty ? '0 : card_a;
      rsp.deck_empty <= deck_empty;
    end
  end

`ifndef SYNTHESIS
  // An empty-deck response always carries card zero.
  a_empty_card: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.deck_empty |-> rsp.card == '0)
    else $error("empty deck response with nonzero card");

  // The swap partner never lies above the swap index.
  a_swap_range: assert property (@(posedge clk) disable iff (rst)
    upc == dsd_pkg::U_SWAP_RD |-> rem <= idx_i)
    else $error("swap partner out of range");

  // The deal position never passes the deck size.
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    deal_pos <= POS_W'(DECK_SIZE))
    else $error("deal position past deck size");

  // A finished shuffle leaves the deal position rewound.
  a_rewind: assert property (@(posedge clk) disable iff (rst)
    upc == dsd_pkg::U_SH_DONE |=> deal_pos == '0)
    else $error("deal position not rewound after shuffle");
`endif

endmodule

// File: verif/deck_shuffle_and_deal_tb.sv
// Self-checking testbench for the deck shuffle and deal engine.
`timescale 1ns / 1ps

module deck_shuffle_and_deal_tb;

  localparam int DECK_CARDS  = 52;
  localparam int LONG_HOLD   = 400;
  localparam int IDLE_LIMIT  = 20000;
  localparam int TAIL_CYCLES = 2000;
  localparam int REPORT_MAX  = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  dsd_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  dsd_pkg::rsp_t rsp;

  // Stimulus and expected results.
  dsd_pkg::req_t pending_reqs[$];
  dsd_pkg::rsp_t expected_cards[$];

  // Predicted engine state.
  logic [31:0] gen_state;
  logic [5:0]  deck_model[DECK_CARDS];
  int          dealt_count;

  // Run control and statistics.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int hold_served    = 0;
  int hold_left      = 0;
  int idle_cycles    = 0;
  int mismatches     = 0;
  int stim_items     = 0;
  int reseeds_taken  = 0;
  int shuffles_taken = 0;
  int deals_taken    = 0;
  int empties_seen   = 0;
  int cards_checked  = 0;

  deck_shuffle_and_deal #(
    .DECK_SIZE(DECK_CARDS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // Clock with an 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Advance the predicted state by one accepted request and queue any card it deals.
  function automatic void apply_request(input dsd_pkg::req_t r);
    logic [5:0]  tmp;
    logic [31:0] x;
    int          j;
    case (r.func)
      dsd_pkg::FUNC_RESEED: begin
        gen_state = gen_state ^ (r.seed_value | 32'd1);
        reseeds_taken++;
      end
      dsd_pkg::FUNC_SHUFFLE: begin
        for (int k = 0; k < DECK_CARDS; k++) deck_model[k] = 6'(k);
        for (int i = DECK_CARDS - 1; i > 0; i--) begin
          x = gen_state;
          x = x ^ (x << 13);
          x = x ^ (x >> 17);
          x = x ^ (x << 5);
          gen_state = x;
          j = int'(x % 32'(i + 1));
          tmp = deck_model[i];
          deck_model[i] = deck_model[j];
          deck_model[j] = tmp;
        end
        dealt_count = 0;
        shuffles_taken++;
      end
      dsd_pkg::FUNC_DEAL: begin
        deals_taken++;
        if (dealt_count >= DECK_CARDS) begin
          expected_cards.push_back('{card: 6'd0, deck_empty: 1'b1});
          empties_seen++;
        end else begin
          expected_cards.push_back('{card: deck_model[dealt_count], deck_empty: 1'b0});
          dealt_count++;
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void report_mismatch(input string what, input dsd_pkg::rsp_t want,
                                          input dsd_pkg::rsp_t got);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("%0t: %s: expected card %0d empty %0b, got card %0d empty %0b",
               $realtime, what, want.card, want.deck_empty, got.card, got.deck_empty);
  endfunction

  // Request driver: predicts on each accepted transaction, then offers the next one.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) apply_request(req);
      if (!req_valid || req_ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req       <= pending_reqs.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Response receiver with random stalls and an occasional long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_ready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= LONG_HOLD;
      rsp_ready   <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Response monitor: compares each dealt card with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_cards.size() == 0) begin
        report_mismatch("unexpected response", '0, rsp);
      end else begin
        if (rsp.card !== expected_cards[0].card ||
            rsp.deck_empty !== expected_cards[0].deck_empty)
          report_mismatch("card mismatch", expected_cards[0], rsp);
        void'(expected_cards.pop_front());
        cards_checked++;
      end
    end
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_req(input dsd_pkg::func_t f, input logic [31:0] s);
    pending_reqs.push_back('{func: f, seed_value: s});
    if (f != dsd_pkg::FUNC_NONE) stim_items++;
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || req_valid || expected_cards.size() != 0)
      @(posedge clk);
  endtask

  function automatic logic [31:0] rand_seed();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return 32'h0;
    if (pick == 1) return 32'hffff_ffff;
    return $urandom();
  endfunction

  // One hand: usually a shuffle, sometimes after a reseed, then a run of deals, sometimes broken up.
  task automatic queue_random_hand();
    int r;
    int n;
    r = $urandom_range(99);
    if (r < 30) push_req(dsd_pkg::FUNC_RESEED, rand_seed());
    if (r < 6) push_req(dsd_pkg::FUNC_NONE, $urandom());
    if (r < 90) push_req(dsd_pkg::FUNC_SHUFFLE, $urandom());
    n = ($urandom_range(99) < 20) ? $urandom_range(58, 50) : $urandom_range(12, 1);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 3) push_req(dsd_pkg::FUNC_RESEED, rand_seed());
      if ($urandom_range(99) < 2) push_req(dsd_pkg::FUNC_NONE, $urandom());
      push_req(dsd_pkg::FUNC_DEAL, $urandom());
    end
  endtask

  task automatic run_random_phase(input int send_pct, input int recv_pct, input int count);
    int goal;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    goal = stim_items + count;
    while (stim_items < goal) queue_random_hand();
    wait_drained();
  endtask

  initial begin
    int deals_before;
    gen_state   = dsd_pkg::RNG_RESET;
    dealt_count = 0;
    for (int k = 0; k < DECK_CARDS; k++) deck_model[k] = 6'(k);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: identity deck after reset, ignored selector, zero generator, seed extremes.
    push_req(dsd_pkg::FUNC_DEAL, 32'h0);
    push_req(dsd_pkg::FUNC_DEAL, 32'hffff_ffff);
    push_req(dsd_pkg::FUNC_NONE, 32'hffff_ffff);
    push_req(dsd_pkg::FUNC_DEAL, 32'h0);
    push_req(dsd_pkg::FUNC_RESEED, 32'habcd_ef00);
    push_req(dsd_pkg::FUNC_DEAL, 32'hffff_ffff);
    push_req(dsd_pkg::FUNC_SHUFFLE, 32'hffff_ffff);
    repeat (3) push_req(dsd_pkg::FUNC_DEAL, 32'h5555_5555);
    push_req(dsd_pkg::FUNC_RESEED, 32'hffff_ffff);
    push_req(dsd_pkg::FUNC_SHUFFLE, 32'h0);
    repeat (3) push_req(dsd_pkg::FUNC_DEAL, 32'haaaa_aaaa);
    push_req(dsd_pkg::FUNC_RESEED, 32'h0);
    push_req(dsd_pkg::FUNC_SHUFFLE, 32'h1234_5678);
    repeat (2) push_req(dsd_pkg::FUNC_DEAL, 32'h0);
    push_req(dsd_pkg::FUNC_RESEED, 32'h8000_0000);
    push_req(dsd_pkg::FUNC_SHUFFLE, 32'h0);
    push_req(dsd_pkg::FUNC_DEAL, 32'h0);
    wait_drained();

    // Pressure: the receiver holds off while deals keep coming, and the deck runs dry.
    push_req(dsd_pkg::FUNC_RESEED, $urandom());
    push_req(dsd_pkg::FUNC_SHUFFLE, $urandom());
    wait_drained();
    deals_before = deals_taken;
    for (int k = 0; k < 58; k++) push_req(dsd_pkg::FUNC_DEAL, $urandom());
    while (deals_taken == deals_before) @(posedge clk);
    hold_requests++;
    wait_drained();

    // Random hands under several idling patterns.
    run_random_phase(0, 0, 62);
    run_random_phase(65, 0, 62);
    run_random_phase(0, 65, 62);
    run_random_phase(9, 9, 62);

    // Let any shuffle still in progress finish before closing out.
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d requests: %0d reseeds, %0d shuffles, %0d deals (%0d on an empty deck).",
             stim_items, reseeds_taken, shuffles_taken, deals_taken, empties_seen);
    $display("Checked %0d dealt cards, %0d mismatches.", cards_checked, mismatches);
    if (mismatches == 0 && expected_cards.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
